### rtl/joint_histogram_engine_macros.svh
// Assertion macros shared by the joint histogram RTL.
// Expects clk_i and rst_ni in the scope of the module that uses them.
`ifndef JOINT_HISTOGRAM_ENGINE_MACROS_SVH
`define JOINT_HISTOGRAM_ENGINE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define JHE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define JHE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/jhe_pkg.sv
// Package for the joint histogram engine: sizes, codes, state and payload types.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps
`default_nettype none
package jhe_pkg;

  // Histogram geometry
  localparam int BINS_A       = 256;
  localparam int BINS_B       = 256;
  localparam int BANDS        = 3;
  localparam int COUNT_BITS   = 21;
  localparam int BIN_PER_BAND = BINS_A * BINS_B;
  localparam int CELLS        = BANDS * BIN_PER_BAND;
  localparam int ADDR_W       = $clog2(CELLS);
  localparam int IDX_A_W      = $clog2(BINS_A);
  localparam int IDX_B_W      = $clog2(BINS_B);
  localparam int BAND_W       = (BANDS > 1) ? $clog2(BANDS) : 1;

  // Result widths and share divider
  localparam int OUT_W     = 21;
  localparam int SHARE_W   = 17;
  localparam int FRAC_BITS = 16;
  localparam int STEP_W    = $clog2(FRAC_BITS);

  // Register port
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [SHARE_W-1:0]    SHARE_ONE = SHARE_W'(1) << FRAC_BITS;

  // Operation codes
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ACC   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_RANGE = 2'd1;
  localparam logic [1:0] STAT_SAT   = 2'd2;

  // Register indexes (word address)
  localparam logic [1:0] REG_ABS_MODE = 2'd0;
  localparam logic [1:0] REG_MIN_A    = 2'd1;
  localparam logic [1:0] REG_MIN_B    = 2'd2;

  typedef logic        [1:0]         opcode_t;
  typedef logic        [1:0]         band_t;
  typedef logic signed [15:0]        sample_t;
  typedef logic        [7:0]         query_t;
  typedef logic        [OUT_W-1:0]   count_out_t;
  typedef logic        [SHARE_W-1:0] share_t;
  typedef logic        [1:0]         status_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_ADDR,
    ST_RD,
    ST_UPD,
    ST_DIV,
    ST_CLR,
    ST_DONE
  } state_e;

  // Fit an internal counter into the result field width
  function automatic count_out_t count_to_out(logic [COUNT_BITS-1:0] c);
    logic [COUNT_BITS+OUT_W-1:0] w;
    w = {{OUT_W{1'b0}}, c};
    return w[OUT_W-1:0];
  endfunction

endpackage
`default_nettype wire

### rtl/jhe_in_if.sv
// Command channel of the joint histogram engine: valid/ready plus operation fields.
// Depends on jhe_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none
interface jhe_in_if;
  logic             valid;
  logic             ready;
  jhe_pkg::opcode_t opcode;
  jhe_pkg::band_t   band;
  jhe_pkg::sample_t sample_a;
  jhe_pkg::sample_t sample_b;
  jhe_pkg::query_t  query_a;
  jhe_pkg::query_t  query_b;

  modport source (
    output valid, opcode, band, sample_a, sample_b, query_a, query_b,
    input  ready
  );
  modport sink (
    input  valid, opcode, band, sample_a, sample_b, query_a, query_b,
    output ready
  );
endinterface
`default_nettype wire

### rtl/jhe_out_if.sv
// Result channel of the joint histogram engine: valid/ready plus result fields.
// Depends on jhe_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none
interface jhe_out_if;
  logic                valid;
  logic                ready;
  jhe_pkg::count_out_t bin_count;
  jhe_pkg::share_t     share;
  jhe_pkg::count_out_t pair_total;
  jhe_pkg::status_t    status;

  modport source (
    output valid, bin_count, share, pair_total, status,
    input  ready
  );
  modport sink (
    input  valid, bin_count, share, pair_total, status,
    output ready
  );
endinterface
`default_nettype wire

### rtl/joint_histogram_engine.sv
// Joint histogram engine top level: sequencer, bin memory, band totals, share divider.
// Depends on jhe_pkg, jhe_in_if, jhe_out_if and joint_histogram_engine_macros.svh.
//
// Usage: each command transfer on in_i (clear band, accumulate pair, read bin) yields
// exactly one result transfer on out_i. Registers abs_mode, min_a and min_b sit on the
// APB port at byte addresses 0, 4 and 8; write them only while the engine is idle.
// One command is in flight at a time; in_i.ready is high only when the sequencer idles.
// After a command transfer, accumulate and read pass through the address, read and update
// states, a read-modify-write of the bin memory; a read then runs the one-bit-per-cycle
// share divider for 16 steps unless the total is zero or the share full. Clear zeroes one
// bin per cycle across its band; a bad band, range or opcode goes straight to the result.
// The next command is taken in the cycle after the result is loaded.
// Results go to an output register, so a stalled receiver does not block the next
// command; a second result waits in the sequencer until the register is free.
// After reset every bin is zeroed by a sweep over all BANDS*BINS_A*BINS_B cells (196608)
// during which no command is taken; register writes are accepted throughout.
`timescale 1ns / 1ps
`default_nettype none
`include "joint_histogram_engine_macros.svh"
module joint_histogram_engine (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  jhe_in_if.sink                            in_i,
  jhe_out_if.source                         out_o,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [jhe_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [jhe_pkg::PDATA_W-1:0]  pwdata,
  output logic      [jhe_pkg::PDATA_W-1:0]  prdata,
  output logic                              pready
);

  localparam int CB = jhe_pkg::COUNT_BITS;
  localparam int AW = jhe_pkg::ADDR_W;

  jhe_pkg::state_e state_q, state_d;

  // Configuration registers
  logic                    abs_mode_q;
  logic signed [15:0]      min_a_q;
  logic signed [15:0]      min_b_q;

  // Band totals and bin memory
  logic [CB-1:0]           band_totals_q [jhe_pkg::BANDS];
  logic [CB-1:0]           mem [jhe_pkg::CELLS];
  logic [CB-1:0]           rdata_q;

  // Command context
  logic [1:0]                    op_q;
  logic [jhe_pkg::BAND_W-1:0]    band_q;
  logic [jhe_pkg::IDX_A_W-1:0]   idx_a_q;
  logic [jhe_pkg::IDX_B_W-1:0]   idx_b_q;
  logic [AW-1:0]                 addr_q;
  logic [AW-1:0]                 clr_addr_q;
  logic [AW-1:0]                 clr_last_q;

  // Result under construction
  logic [CB-1:0]                 res_count_q;
  logic [jhe_pkg::SHARE_W-1:0]   res_share_q;
  logic [CB-1:0]                 res_total_q;
  logic [1:0]                    res_status_q;

  // Share divider
  logic [CB-1:0]                   rem_q;
  logic [jhe_pkg::FRAC_BITS-1:0]   quo_q;
  logic [jhe_pkg::STEP_W-1:0]      step_q;
  logic [CB:0]                     rem_dbl;
  logic                            div_ge;
  logic [CB:0]                     rem_sub;
  logic [CB-1:0]                   rem_nxt;
  logic                            div_last;

  // Output register
  logic                          out_vld_q;
  jhe_pkg::count_out_t           out_count_q;
  jhe_pkg::share_t               out_share_q;
  jhe_pkg::count_out_t           out_total_q;
  jhe_pkg::status_t              out_status_q;

  // Control strobes
  logic          in_rdy;
  logic          in_fire;
  logic          out_free;
  logic          out_load;
  logic          mem_we;
  logic          mem_re;
  logic [AW-1:0] mem_waddr;
  logic [CB-1:0] mem_wdata;
  logic          clr_done;
  logic          cfg_wr;

  // Command decode
  logic                        band_ok;
  logic [jhe_pkg::BAND_W-1:0]  band_idx;
  logic [CB-1:0]               cur_total;
  logic signed [17:0]          sa_x, sb_x, mna_x, mnb_x;
  logic signed [17:0]          bin_a, bin_b;
  logic [16:0]                 mag_a, mag_b;
  logic                        acc_oor;
  logic                        qry_oor;
  logic [jhe_pkg::IDX_A_W+7:0] qa_w;
  logic [jhe_pkg::IDX_B_W+7:0] qb_w;
  logic [CB-1:0]               inc_count;
  logic [CB-1:0]               inc_total;
  logic [AW-1:0]               band_base;

  // ---------------------------------------------------------------------------
  // Command decode: band check, bin indices, range checks
  assign band_ok  = 32'(in_i.band) < 32'(jhe_pkg::BANDS);
  assign band_idx = in_i.band[jhe_pkg::BAND_W-1:0];
  assign cur_total = band_ok ? band_totals_q[band_idx] : '0;
  assign band_base = AW'(band_idx * jhe_pkg::BIN_PER_BAND);

  assign sa_x  = {{2{in_i.sample_a[15]}}, in_i.sample_a};
  assign sb_x  = {{2{in_i.sample_b[15]}}, in_i.sample_b};
  assign mna_x = {{2{min_a_q[15]}}, min_a_q};
  assign mnb_x = {{2{min_b_q[15]}}, min_b_q};

  always_comb begin
    if (abs_mode_q) begin
      bin_a = sa_x[17] ? -sa_x : sa_x;
      bin_b = sb_x[17] ? -sb_x : sb_x;
    end else begin
      bin_a = sa_x - mna_x;
      bin_b = sb_x - mnb_x;
    end
  end

  assign mag_a   = bin_a[16:0];
  assign mag_b   = bin_b[16:0];
  assign acc_oor = bin_a[17] || bin_b[17] ||
                   (32'(mag_a) >= 32'(jhe_pkg::BINS_A)) ||
                   (32'(mag_b) >= 32'(jhe_pkg::BINS_B));
  assign qry_oor = (32'(in_i.query_a) >= 32'(jhe_pkg::BINS_A)) ||
                   (32'(in_i.query_b) >= 32'(jhe_pkg::BINS_B));
  assign qa_w    = {{jhe_pkg::IDX_A_W{1'b0}}, in_i.query_a};
  assign qb_w    = {{jhe_pkg::IDX_B_W{1'b0}}, in_i.query_b};

  // Saturating increments for the read-modify-write
  assign inc_count = (rdata_q == jhe_pkg::COUNT_MAX) ? rdata_q : rdata_q + 1'b1;
  assign inc_total = (band_totals_q[band_q] == jhe_pkg::COUNT_MAX) ?
                     band_totals_q[band_q] : band_totals_q[band_q] + 1'b1;

  // Shared compare/subtract step of the restoring divider
  assign rem_dbl  = {rem_q, 1'b0};
  assign div_ge   = rem_dbl >= {1'b0, res_total_q};
  assign rem_sub  = rem_dbl - {1'b0, res_total_q};
  assign rem_nxt  = div_ge ? rem_sub[CB-1:0] : rem_dbl[CB-1:0];
  assign div_last = step_q == jhe_pkg::STEP_W'(jhe_pkg::FRAC_BITS - 1);

  assign clr_done = clr_addr_q == clr_last_q;
  assign out_free = !out_vld_q || out_o.ready;
  assign in_fire  = in_i.valid && in_rdy;

  // ---------------------------------------------------------------------------
  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      jhe_pkg::ST_INIT: begin
        if (clr_done) state_d = jhe_pkg::ST_IDLE;
      end
      jhe_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (in_i.opcode)
            jhe_pkg::OP_CLEAR: state_d = band_ok ? jhe_pkg::ST_CLR : jhe_pkg::ST_DONE;
            jhe_pkg::OP_ACC: begin
              state_d = (band_ok && !acc_oor) ? jhe_pkg::ST_ADDR : jhe_pkg::ST_DONE;
            end
            jhe_pkg::OP_READ: begin
              state_d = (band_ok && !qry_oor) ? jhe_pkg::ST_ADDR : jhe_pkg::ST_DONE;
            end
            default: state_d = jhe_pkg::ST_DONE;
          endcase
        end
      end
      jhe_pkg::ST_ADDR: state_d = jhe_pkg::ST_RD;
      jhe_pkg::ST_RD:   state_d = jhe_pkg::ST_UPD;
      jhe_pkg::ST_UPD: begin
        if (op_q == jhe_pkg::OP_READ && res_total_q != '0 && rdata_q < res_total_q) begin
          state_d = jhe_pkg::ST_DIV;
        end else begin
          state_d = jhe_pkg::ST_DONE;
        end
      end
      jhe_pkg::ST_DIV: begin
        if (div_last) state_d = jhe_pkg::ST_DONE;
      end
      jhe_pkg::ST_CLR: begin
        if (clr_done) state_d = jhe_pkg::ST_DONE;
      end
      jhe_pkg::ST_DONE: begin
        if (out_free) state_d = jhe_pkg::ST_IDLE;
      end
      default: state_d = jhe_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control outputs of the sequencer
  always_comb begin
    in_rdy    = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = clr_addr_q;
    mem_wdata = '0;
    out_load  = 1'b0;
    case (state_q)
      jhe_pkg::ST_INIT: mem_we = 1'b1;
      jhe_pkg::ST_IDLE: in_rdy = 1'b1;
      jhe_pkg::ST_RD:   mem_re = 1'b1;
      jhe_pkg::ST_UPD: begin
        mem_we    = op_q == jhe_pkg::OP_ACC;
        mem_waddr = addr_q;
        mem_wdata = inc_count;
      end
      jhe_pkg::ST_CLR:  mem_we = 1'b1;
      jhe_pkg::ST_DONE: out_load = out_free;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Bin memory: one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= mem[addr_q];
  end

  // ---------------------------------------------------------------------------
  // Sequencer state, totals, sweep pointer and divider step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= jhe_pkg::ST_INIT;
      clr_addr_q <= '0;
      clr_last_q <= AW'(jhe_pkg::CELLS - 1);
      step_q     <= '0;
      for (int i = 0; i < jhe_pkg::BANDS; i++) band_totals_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (in_fire && in_i.opcode == jhe_pkg::OP_CLEAR && band_ok) begin
        clr_addr_q              <= band_base;
        clr_last_q              <= band_base + AW'(jhe_pkg::BIN_PER_BAND - 1);
        band_totals_q[band_idx] <= '0;
      end
      if ((state_q == jhe_pkg::ST_INIT || state_q == jhe_pkg::ST_CLR) && !clr_done) begin
        clr_addr_q <= clr_addr_q + 1'b1;
      end
      if (state_q == jhe_pkg::ST_UPD && op_q == jhe_pkg::OP_ACC) begin
        band_totals_q[band_q] <= inc_total;
      end
      if (state_q == jhe_pkg::ST_UPD) step_q <= '0;
      else if (state_q == jhe_pkg::ST_DIV) step_q <= step_q + 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Command context and result datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      jhe_pkg::ST_IDLE: begin
        if (in_fire) begin
          op_q         <= in_i.opcode;
          band_q       <= band_idx;
          res_count_q  <= '0;
          res_share_q  <= '0;
          res_total_q  <= cur_total;
          res_status_q <= jhe_pkg::STAT_OK;
          if (in_i.opcode == jhe_pkg::OP_READ) begin
            idx_a_q <= qa_w[jhe_pkg::IDX_A_W-1:0];
            idx_b_q <= qb_w[jhe_pkg::IDX_B_W-1:0];
          end else begin
            idx_a_q <= mag_a[jhe_pkg::IDX_A_W-1:0];
            idx_b_q <= mag_b[jhe_pkg::IDX_B_W-1:0];
          end
          case (in_i.opcode)
            jhe_pkg::OP_CLEAR: begin
              res_total_q <= '0;
              if (!band_ok) res_status_q <= jhe_pkg::STAT_RANGE;
            end
            jhe_pkg::OP_ACC: begin
              if (!band_ok || acc_oor) res_status_q <= jhe_pkg::STAT_RANGE;
            end
            jhe_pkg::OP_READ: begin
              if (!band_ok || qry_oor) res_status_q <= jhe_pkg::STAT_RANGE;
            end
            default: res_total_q <= '0;
          endcase
        end
      end
      jhe_pkg::ST_ADDR: begin
        addr_q <= AW'(band_q * jhe_pkg::BIN_PER_BAND) +
                  AW'(idx_b_q * jhe_pkg::BINS_A) + AW'(idx_a_q);
      end
      jhe_pkg::ST_UPD: begin
        if (op_q == jhe_pkg::OP_ACC) begin
          res_total_q <= inc_total;
          if (rdata_q == jhe_pkg::COUNT_MAX ||
              band_totals_q[band_q] == jhe_pkg::COUNT_MAX) begin
            res_status_q <= jhe_pkg::STAT_SAT;
          end
        end else begin
          res_count_q <= rdata_q;
          rem_q       <= rdata_q;
          quo_q       <= '0;
          if (res_total_q != '0 && rdata_q >= res_total_q) begin
            res_share_q <= jhe_pkg::SHARE_ONE;
          end
        end
      end
      jhe_pkg::ST_DIV: begin
        rem_q <= rem_nxt;
        quo_q <= {quo_q[jhe_pkg::FRAC_BITS-2:0], div_ge};
        if (div_last) begin
          res_share_q <= {1'b0, quo_q[jhe_pkg::FRAC_BITS-2:0], div_ge};
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_count_q  <= jhe_pkg::count_to_out(res_count_q);
      out_share_q  <= res_share_q;
      out_total_q  <= jhe_pkg::count_to_out(res_total_q);
      out_status_q <= res_status_q;
    end
  end

  assign in_i.ready       = in_rdy;
  assign out_o.valid      = out_vld_q;
  assign out_o.bin_count  = out_count_q;
  assign out_o.share      = out_share_q;
  assign out_o.pair_total = out_total_q;
  assign out_o.status     = out_status_q;

  // ---------------------------------------------------------------------------
  // APB register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      abs_mode_q <= 1'b0;
      min_a_q    <= '0;
      min_b_q    <= '0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        jhe_pkg::REG_ABS_MODE: abs_mode_q <= pwdata[0];
        jhe_pkg::REG_MIN_A:    min_a_q    <= pwdata[15:0];
        jhe_pkg::REG_MIN_B:    min_b_q    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      jhe_pkg::REG_ABS_MODE: prdata = {{(jhe_pkg::PDATA_W-1){1'b0}}, abs_mode_q};
      jhe_pkg::REG_MIN_A:    prdata = {{(jhe_pkg::PDATA_W-16){1'b0}}, min_a_q};
      jhe_pkg::REG_MIN_B:    prdata = {{(jhe_pkg::PDATA_W-16){1'b0}}, min_b_q};
      default:               prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Assertions
  `JHE_ASSERT_NOW(a_div_rem_below, state_q == jhe_pkg::ST_DIV, rem_q < res_total_q, "divider remainder not below total")
  `JHE_ASSERT_NOW(a_clr_in_band, state_q == jhe_pkg::ST_CLR, clr_addr_q <= clr_last_q, "clear sweep ran past its band")
  `JHE_ASSERT_NEXT(a_hold_result, state_q == jhe_pkg::ST_DONE && out_vld_q && !out_o.ready, state_q == jhe_pkg::ST_DONE, "result left sequencer while output register busy")
  `JHE_ASSERT_NEXT(a_busy_after_cmd, in_fire, !in_rdy, "command transfer did not make engine busy")

endmodule
`default_nettype wire

### tb/jhe_histogram_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the joint histogram engine: watches the command, result and register
// ports, models the bins and band totals, and compares each result transfer.
// Depends on jhe_pkg, jhe_in_if and jhe_out_if from the RTL.
module jhe_histogram_checker
  import jhe_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  jhe_in_if                   cmd_i,
  jhe_out_if                  res_i,
  input  logic                psel_i,
  input  logic                penable_i,
  input  logic                pwrite_i,
  input  logic                pready_i,
  input  logic [PADDR_W-1:0]  paddr_i,
  input  logic [PDATA_W-1:0]  pwdata_i,
  output int unsigned         mismatches_o,
  output int unsigned         pending_o
);

  typedef struct packed {
    count_out_t bin_count;
    share_t     share;
    count_out_t pair_total;
    status_t    status;
  } hist_result_t;

  // Model of the histogram memory and per-band pair totals
  bit [COUNT_BITS-1:0] bin_tally  [CELLS];
  bit [COUNT_BITS-1:0] band_pairs [BANDS];

  // Shadow of the register file
  logic          abs_sel;
  logic [15:0]   floor_a;
  logic [15:0]   floor_b;

  hist_result_t  owed_results [$];
  int unsigned   fail_tally = 0;

  task automatic report_mismatch(string msg);
    $display("%0t ns  histogram mismatch: %s", $time, msg);
    fail_tally++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    end
  endtask

  // Bin index of one sample under the current binning mode
  function automatic int bin_index(sample_t s, logic [15:0] floor_v);
    if (abs_sel) begin
      return (s < 0) ? -int'(s) : int'(s);
    end
    return int'(s) - int'($signed(floor_v));
  endfunction

  // Apply one command to the model and return the result it owes
  function automatic hist_result_t apply_command(opcode_t op, band_t bd, sample_t sa,
                                                 sample_t sb, query_t qa, query_t qb);
    hist_result_t        r;
    int                  ia;
    int                  ib;
    int unsigned         cell_idx;
    logic [63:0]         quot;
    r = '0;
    if (op != OP_CLEAR && op != OP_ACC && op != OP_READ) begin
      return r;
    end
    if (int'(bd) >= BANDS) begin
      r.status = STAT_RANGE;
      return r;
    end
    case (op)
      OP_CLEAR: begin
        for (int i = 0; i < BIN_PER_BAND; i++) begin
          bin_tally[int'(bd) * BIN_PER_BAND + i] = '0;
        end
        band_pairs[bd] = '0;
      end
      OP_ACC: begin
        ia = bin_index(sa, floor_a);
        ib = bin_index(sb, floor_b);
        if (ia < 0 || ib < 0 || ia >= BINS_A || ib >= BINS_B) begin
          r.status = STAT_RANGE;
        end else begin
          cell_idx = (int'(bd) * BINS_B + ib) * BINS_A + ia;
          // both counters stop at full scale
          if (bin_tally[cell_idx] == COUNT_MAX) begin
            r.status = STAT_SAT;
          end else begin
            bin_tally[cell_idx]++;
          end
          if (band_pairs[bd] == COUNT_MAX) begin
            r.status = STAT_SAT;
          end else begin
            band_pairs[bd]++;
          end
        end
        r.pair_total = band_pairs[bd];
      end
      default: begin
        r.pair_total = band_pairs[bd];
        if (int'(qa) >= BINS_A || int'(qb) >= BINS_B) begin
          r.status = STAT_RANGE;
        end else begin
          r.bin_count = bin_tally[(int'(bd) * BINS_B + int'(qb)) * BINS_A + int'(qa)];
          if (band_pairs[bd] != 0) begin
            quot = (64'(r.bin_count) << FRAC_BITS) / 64'(band_pairs[bd]);
            r.share = (quot > 64'(SHARE_ONE)) ? SHARE_ONE : share_t'(quot);
          end
        end
      end
    endcase
    return r;
  endfunction

  // Register writes, result compare, then new commands
  always @(posedge clk_i or negedge rst_ni) begin
    hist_result_t want;
    if (!rst_ni) begin
      abs_sel = 1'b0;
      floor_a = '0;
      floor_b = '0;
      foreach (bin_tally[i]) bin_tally[i] = '0;
      foreach (band_pairs[i]) band_pairs[i] = '0;
      owed_results.delete();
      pending_o <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[PADDR_W-1:2])
          REG_ABS_MODE: abs_sel = pwdata_i[0];
          REG_MIN_A:    floor_a = pwdata_i[15:0];
          REG_MIN_B:    floor_b = pwdata_i[15:0];
          default: ;
        endcase
      end
      if (res_i.valid && res_i.ready) begin
        if (owed_results.size() == 0) begin
          report_mismatch("result transfer with no command outstanding");
        end else begin
          want = owed_results.pop_front();
          check_field("bin_count", 32'(res_i.bin_count), 32'(want.bin_count));
          check_field("share", 32'(res_i.share), 32'(want.share));
          check_field("pair_total", 32'(res_i.pair_total), 32'(want.pair_total));
          check_field("status", 32'(res_i.status), 32'(want.status));
        end
      end
      if (cmd_i.valid && cmd_i.ready) begin
        owed_results = {owed_results, apply_command(cmd_i.opcode, cmd_i.band,
                                                    cmd_i.sample_a, cmd_i.sample_b,
                                                    cmd_i.query_a, cmd_i.query_b)};
      end
      pending_o <= owed_results.size();
    end
    mismatches_o <= fail_tally;
  end

endmodule

### tb/joint_histogram_engine_tb.sv
`timescale 1ns / 1ps
// Testbench top for the joint histogram engine: clock, reset, register writes,
// directed and random command streams with sender gaps and receiver stalls.
// Depends on the RTL (jhe_pkg, channel interfaces, engine) and jhe_histogram_checker.
module joint_histogram_engine_tb;
  import jhe_pkg::*;

  localparam opcode_t OP_UNUSED = 2'd3;
  localparam int      RUN_LIMIT = 3_000_000;
  localparam int      PHASE_CMDS = 400;

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;
  int unsigned         mismatches;
  int unsigned         pending;

  jhe_in_if  cmd_ch ();
  jhe_out_if res_ch ();

  joint_histogram_engine dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (cmd_ch),
    .out_o   (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  jhe_histogram_checker checker_u (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd_ch),
    .res_i        (res_ch),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  // Stimulus-side copy of the binning setup, used only to aim samples at bins
  logic          abs_on;
  logic [15:0]   aim_floor_a;
  logic [15:0]   aim_floor_b;
  int unsigned   burst_left = 0;
  int unsigned   clears_left = 3;
  int unsigned   cycles_run = 0;
  int unsigned   stall_mode = 0;
  int unsigned   stall_left = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Receiver: switches among free-running, light, heavy and periodic stalling
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 200);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: res_ch.ready <= 1'b1;
      1: res_ch.ready <= ($urandom_range(0, 3) != 0);
      2: res_ch.ready <= ($urandom_range(0, 3) == 0);
      default: res_ch.ready <= ((stall_left % 16) < 4);
    endcase
  end

  // Watchdog
  initial begin
    while (cycles_run < RUN_LIMIT) begin
      @(posedge clk_i);
      cycles_run++;
    end
    $display("** joint_histogram_engine: FAILED **");
    $finish;
  end

  // Two-phase register write; returns only after psel is dropped, so writes never overlap
  task automatic write_reg(logic [1:0] idx, logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(logic abs_v, logic [15:0] fa, logic [15:0] fb);
    write_reg(REG_ABS_MODE, PDATA_W'(abs_v));
    write_reg(REG_MIN_A, {{16{fa[15]}}, fa});
    write_reg(REG_MIN_B, {{16{fb[15]}}, fb});
    abs_on      = abs_v;
    aim_floor_a = fa;
    aim_floor_b = fb;
  endtask

  // One command transfer; bursts of random length usually separated by random gaps
  task automatic send_cmd(opcode_t op, band_t bd, sample_t sa, sample_t sb,
                          query_t qa, query_t qb);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        cmd_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 30)) @(posedge clk_i);
      end
    end
    burst_left--;
    cmd_ch.valid    <= 1'b1;
    cmd_ch.opcode   <= op;
    cmd_ch.band     <= bd;
    cmd_ch.sample_a <= sa;
    cmd_ch.sample_b <= sb;
    cmd_ch.query_a  <= qa;
    cmd_ch.query_b  <= qb;
    do @(posedge clk_i); while (!cmd_ch.ready);
  endtask

  // Hold off the sender until every owed result has come back
  task automatic drain();
    cmd_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Sample aimed near a hot window of bins, at the range edges, or anywhere
  function automatic sample_t shape_sample(logic [15:0] floor_v, int unsigned hot);
    int pick;
    int idx;
    int v;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      return sample_t'($urandom);
    end
    if (pick == 1) begin
      case ($urandom_range(0, 3))
        0: idx = -1;
        1: idx = 0;
        2: idx = BINS_A - 1;
        default: idx = BINS_A;
      endcase
    end else begin
      idx = int'(hot + $urandom_range(0, 7));
    end
    if (abs_on) begin
      v = ($urandom_range(0, 1) == 1) ? -idx : idx;
    end else begin
      v = idx + int'($signed(floor_v));
    end
    return sample_t'(v);
  endfunction

  // Random phase: mostly accumulates and reads on a hot window, some noise
  task automatic run_phase(int unsigned cmds);
    int unsigned hot_a;
    int unsigned hot_b;
    int unsigned op_roll;
    opcode_t     op;
    band_t       bd;
    query_t      qa;
    query_t      qb;
    hot_a = $urandom_range(0, 248);
    hot_b = $urandom_range(0, 248);
    repeat (cmds) begin
      op_roll = $urandom_range(0, 99);
      if (op_roll < 3) begin
        op = OP_UNUSED;
      end else if (op_roll == 3 && clears_left > 0) begin
        op = OP_CLEAR;
        clears_left--;
      end else if (op_roll < 30) begin
        op = OP_READ;
      end else begin
        op = OP_ACC;
      end
      bd = ($urandom_range(0, 19) == 0) ? band_t'(3) : band_t'($urandom_range(0, 2));
      qa = ($urandom_range(0, 4) == 0) ? query_t'($urandom) :
                                         query_t'(hot_a + $urandom_range(0, 7));
      qb = ($urandom_range(0, 4) == 0) ? query_t'($urandom) :
                                         query_t'(hot_b + $urandom_range(0, 7));
      send_cmd(op, bd, shape_sample(aim_floor_a, hot_a), shape_sample(aim_floor_b, hot_b),
               qa, qb);
    end
  endtask

  // Main sequence
  initial begin
    rst_ni          <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    cmd_ch.valid    <= 1'b0;
    cmd_ch.opcode   <= OP_CLEAR;
    cmd_ch.band     <= '0;
    cmd_ch.sample_a <= '0;
    cmd_ch.sample_b <= '0;
    cmd_ch.query_a  <= '0;
    cmd_ch.query_b  <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Offset binning with zero minimums; the post-reset bin sweep runs meanwhile
    set_config(1'b0, 16'sd0, 16'sd0);
    send_cmd(OP_READ, 2'd0, 16'sd0, 16'sd0, 8'd0, 8'd0);            // zero total
    send_cmd(OP_ACC, 2'd0, 16'sd0, 16'sd0, 8'd0, 8'd0);
    send_cmd(OP_ACC, 2'd0, 16'sd255, 16'sd255, 8'd0, 8'd0);
    send_cmd(OP_ACC, 2'd0, 16'sd0, 16'sd0, 8'd0, 8'd0);
    send_cmd(OP_ACC, 2'd0, 16'sd256, 16'sd0, 8'd0, 8'd0);           // index too high
    send_cmd(OP_ACC, 2'd0, 16'sd0, -16'sd1, 8'd0, 8'd0);            // index negative
    send_cmd(OP_ACC, 2'd1, 16'sd10, 16'sd20, 8'd0, 8'd0);
    send_cmd(OP_ACC, 2'd3, 16'sd1, 16'sd1, 8'd0, 8'd0);             // band out of range
    send_cmd(OP_READ, 2'd0, 16'sd0, 16'sd0, 8'd0, 8'd0);
    send_cmd(OP_READ, 2'd1, 16'sd0, 16'sd0, 8'd10, 8'd20);          // full share
    send_cmd(OP_READ, 2'd0, 16'sd0, 16'sd0, 8'd255, 8'd255);
    send_cmd(OP_READ, 2'd3, 16'sd0, 16'sd0, 8'd0, 8'd0);
    send_cmd(OP_UNUSED, 2'd3, -16'sd1, -16'sd1, 8'd255, 8'd255);
    send_cmd(OP_CLEAR, 2'd3, 16'sd0, 16'sd0, 8'd0, 8'd0);
    send_cmd(OP_ACC, 2'd2, 16'sd1, 16'sd1, 8'd0, 8'd0);
    send_cmd(OP_CLEAR, 2'd2, 16'sd0, 16'sd0, 8'd0, 8'd0);
    send_cmd(OP_READ, 2'd2, 16'sd0, 16'sd0, 8'd1, 8'd1);            // cleared band
    drain();

    // Absolute-value binning, including the most negative sample
    set_config(1'b1, 16'sd0, 16'sd0);
    send_cmd(OP_ACC, 2'd0, sample_t'(-32768), 16'sd0, 8'd0, 8'd0);
    send_cmd(OP_ACC, 2'd0, -16'sd5, 16'sd7, 8'd0, 8'd0);
    send_cmd(OP_ACC, 2'd0, 16'sd32767, 16'sd0, 8'd0, 8'd0);
    send_cmd(OP_READ, 2'd0, 16'sd0, 16'sd0, 8'd5, 8'd7);
    drain();

    // Extreme minimums
    set_config(1'b0, sample_t'(-32768), 16'sd32767);
    send_cmd(OP_ACC, 2'd1, sample_t'(-32768), 16'sd32767, 8'd0, 8'd0);
    send_cmd(OP_ACC, 2'd1, 16'sd32767, 16'sd32767, 8'd0, 8'd0);
    send_cmd(OP_ACC, 2'd1, sample_t'(-32768), sample_t'(-32768), 8'd0, 8'd0);
    send_cmd(OP_READ, 2'd1, 16'sd0, 16'sd0, 8'd0, 8'd0);
    drain();

    // Random phases, each under its own register setting
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: set_config(1'b1, 16'($urandom), 16'($urandom));
        1: set_config(1'b0, sample_t'(-32768), sample_t'(32767 - 255));
        default: set_config(1'b0, sample_t'(int'($urandom_range(0, 65535 - 255)) - 32768),
                            sample_t'(int'($urandom_range(0, 65535 - 255)) - 32768));
      endcase
      run_phase(PHASE_CMDS);
      drain();
    end

    repeat (30) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("** joint_histogram_engine: PASSED **");
    end else begin
      $display("** joint_histogram_engine: FAILED **");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/jhe_pkg.sv
rtl/jhe_in_if.sv
rtl/jhe_out_if.sv
rtl/joint_histogram_engine.sv
tb/jhe_histogram_checker.sv
tb/joint_histogram_engine_tb.sv
